// ===== sv/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and codes for the sorted table binary search unit.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // Fixed field widths of the request and response beats.
  localparam int unsigned KEY_W = 32;
  localparam int unsigned OP_W  = 2;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned ST_W  = 2;

  // Operation codes. The unused code behaves as a find.
  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

  // Request beat.
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
  } req_t;

  // Response beat.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] count;
    logic [ST_W-1:0]  status;
  } rsp_t;

endpackage

// ===== sv/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sorted_table_binary_search_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit
// Sorted signed key table with binary search, insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_valid/req_ready, payload req) carries an operation
//   and a key: find, insert or delete. Each request gives exactly one
//   response beat (rsp_valid/rsp_ready, payload rsp) with the found flag,
//   the index, the entry count after the operation and a status.
//   The block works on one request at a time; req_ready is high only while
//   no request is in progress. Each probe is a RAM read, then a compare,
//   with at most log2(DEPTH)+1 probes, and a search that ends without a
//   match finishes on the empty window. A request passes through accept,
//   the probes, decide and response. An insert or delete that moves
//   entries runs a shift pass, one entry per cycle, then drains the read
//   and finishes; with nothing to move it only finishes. The worst case
//   is an insert at the front of a table one short of full.
//   A finished response sits in an output register, so the next request is
//   taken while the receiver stalls; a second finished response waits in
//   the sequencer until the first is taken.
//   Reset empties the table (count zero); the RAM itself is not cleared,
//   and only entries below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
  parameter int unsigned DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  stbs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output stbs_pkg::rsp_t rsp
);

  import stbs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SRCH   = 6'b000010,
    S_CMP    = 6'b000100,
    S_DECIDE = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  // Request and search registers.
  logic [OP_W-1:0]         op;
  logic signed [KEY_W-1:0] key;
  logic [CW-1:0]           count, count_next;
  logic [CW-1:0]           lo, lo_next;
  logic [CW-1:0]           hp1, hp1_next;
  logic [AW-1:0]           mid, mid_next;
  logic                    found, found_next;
  logic [CW-1:0]           index, index_next;
  logic [ST_W-1:0]         status, status_next;

  // Shift registers.
  logic [CW-1:0] moves, moves_next;
  logic [AW-1:0] src, src_next;
  logic [AW-1:0] wr_addr, wr_addr_next;
  logic          pend, pend_next;
  logic          up, up_next;

  // RAM port signals.
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [KEY_W-1:0]        wdata;
  logic [AW-1:0]           raddr;
  logic [KEY_W-1:0]        rdata;

  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_c;
  logic          rsp_load;

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Floor midpoint of the window [lo, hp1-1].
  assign mid_sum = {1'b0, lo} + {1'b0, hp1} - {{CW{1'b0}}, 1'b1};
  assign mid_c   = AW'(mid_sum >> 1);

  assign req_ready = (state == S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // Sequencer: search probes, then any shift pass, then the response.
  always_comb begin
    state_next   = state;
    count_next   = count;
    lo_next      = lo;
    hp1_next     = hp1;
    mid_next     = mid;
    found_next   = found;
    index_next   = index;
    status_next  = status;
    moves_next   = moves;
    src_next     = src;
    wr_addr_next = wr_addr;
    pend_next    = pend;
    up_next      = up;
    we           = 1'b0;
    waddr        = wr_addr;
    wdata        = rdata;
    raddr        = mid_c;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          lo_next     = '0;
          hp1_next    = count;
          found_next  = 1'b0;
          status_next = ST_OK;
          state_next  = S_SRCH;
        end
      end

      S_SRCH: begin
        // Issue the probe read, or end the search when the window is empty.
        if (lo < hp1) begin
          mid_next   = mid_c;
          state_next = S_CMP;
        end else begin
          state_next = S_DECIDE;
        end
      end

      S_CMP: begin
        if ($signed(rdata) > key) begin
          hp1_next   = CW'(mid);
          state_next = S_SRCH;
        end else begin
          lo_next = CW'(mid) + CW'(1);
          if ($signed(rdata) == key) begin
            found_next = 1'b1;
            state_next = S_DECIDE;
          end else begin
            state_next = S_SRCH;
          end
        end
      end

      S_DECIDE: begin
        // Pick the response index and set up the shift pass.
        index_next = found ? CW'(mid) : lo;
        pend_next  = 1'b0;
        state_next = S_DONE;
        if (op == OP_INSERT) begin
          index_next = lo;
          if (count == CW'(DEPTH)) begin
            status_next = ST_FULL;
          end else begin
            moves_next = count - lo;
            src_next   = AW'(count - CW'(1));
            up_next    = 1'b1;
            state_next = S_SHIFT;
          end
        end else if (op == OP_DELETE) begin
          if (!found) begin
            status_next = ST_NOTFOUND;
          end else begin
            moves_next = count - CW'(mid) - CW'(1);
            src_next   = mid + AW'(1);
            up_next    = 1'b0;
            state_next = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // Read one entry per cycle; write it one place over in the next cycle.
        raddr = src;
        if (pend) begin
          we = 1'b1;
        end
        if (moves != '0) begin
          wr_addr_next = up ? src + AW'(1) : src - AW'(1);
          src_next     = up ? src - AW'(1) : src + AW'(1);
          moves_next   = moves - CW'(1);
          pend_next    = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            if (up) begin
              we         = 1'b1;
              waddr      = AW'(lo);
              wdata      = key;
              count_next = count + CW'(1);
            end else begin
              count_next = count - CW'(1);
            end
            state_next = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      op  <= req.op;
      key <= req.key;
    end
    lo      <= lo_next;
    hp1     <= hp1_next;
    mid     <= mid_next;
    found   <= found_next;
    index   <= index_next;
    status  <= status_next;
    moves   <= moves_next;
    src     <= src_next;
    wr_addr <= wr_addr_next;
    up      <= up_next;
    if (rsp_load) begin
      rsp.found  <= found;
      rsp.index  <= IDX_W'(index);
      rsp.count  <= IDX_W'(count);
      rsp.status <= status;
    end
  end

endmodule

// ===== sim/sorted_table_binary_search_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit_tb
// Self-checking testbench for the sorted key table search unit. A short
// table of directed requests covers the empty table, the key extremes,
// duplicates, the spare op code and delete misses. Random requests then fill
// the table to full, keep pushing against the full limit, and drain it again.
// Every response beat is checked field by field against a behavioral table
// kept in the testbench, with random gaps on both sides and one long stall.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned RANDOM_ITEMS = 725;
  localparam int unsigned MAX_GAP = 17;
  localparam int unsigned HOLD_OFF_AT = 120;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned FULL_ITEMS = 80;
  localparam int unsigned MAX_REPORTS = 10;

  // The fourth op code is not used by the block and acts as a find.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Directed stimulus row; typed rows carry their own expected response.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic             typed;
    logic             found;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] count;
    logic [ST_W-1:0]  status;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{OP_FIND,   32'h0000_0000, 1'b1, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_DELETE, 32'h0000_0005, 1'b1, 1'b0, 9'd0, 9'd0, ST_NOTFOUND},
    '{OP_SPARE,  32'h0000_0007, 1'b1, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_INSERT, 32'h8000_0000, 1'b1, 1'b0, 9'd0, 9'd1, ST_OK},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b0, 9'd1, 9'd2, ST_OK},
    '{OP_INSERT, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_INSERT, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_INSERT, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_INSERT, 32'h0000_0001, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_FIND,   32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_FIND,   32'h8000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_FIND,   32'h7FFF_FFFF, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_FIND,   32'h0000_0002, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_SPARE,  32'h0000_0001, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_SPARE,  32'h7FFF_FFFE, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_DELETE, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_DELETE, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_DELETE, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_DELETE, 32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_DELETE, 32'h7FFF_FFFF, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_DELETE, 32'h8000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_INSERT, 32'h8000_0000, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_DELETE, 32'h7FFF_FFFF, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK},
    '{OP_FIND,   32'hFFFF_FFFF, 1'b0, 1'b0, 9'd0, 9'd0, ST_OK}
  };

  // Random traffic moves through these stages of table occupancy.
  typedef enum logic [1:0] {
    PH_FILL,
    PH_FULL,
    PH_DRAIN,
    PH_MIX
  } load_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Shadow copy of the sorted table.
  logic signed [KEY_W-1:0] held_keys [TABLE_DEPTH];
  int unsigned held_count = 0;

  rsp_t pending_rsps [$];
  int unsigned sent_beats = 0;
  int unsigned rcvd_beats = 0;
  int unsigned error_count = 0;

  sorted_table_binary_search_unit #(
    .DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one request to the shadow table and returns its response.
  function automatic rsp_t apply_table_op(req_t r);
    logic signed [KEY_W-1:0] k;
    int lo;
    int hi;
    int mid;
    int i;
    logic hit;
    int unsigned pos;
    rsp_t res;
    k = r.key;
    lo = 0;
    hi = int'(held_count) - 1;
    mid = 0;
    hit = 1'b0;
    // Binary search with floor midpoints, stopping at the first equal probe.
    while (lo <= hi && !hit) begin
      mid = (lo + hi) / 2;
      if (held_keys[mid] == k) hit = 1'b1;
      if (held_keys[mid] > k) hi = mid - 1;
      else lo = mid + 1;
    end
    pos = hit ? mid : lo;
    res.status = ST_OK;
    if (r.op == OP_INSERT) begin
      pos = lo;
      if (held_count >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (i = int'(held_count); i > lo; i--) held_keys[i] = held_keys[i-1];
        held_keys[lo] = k;
        held_count++;
      end
    end else if (r.op == OP_DELETE) begin
      if (hit) begin
        for (i = mid; i + 1 < int'(held_count); i++) held_keys[i] = held_keys[i+1];
        held_count--;
      end else begin
        res.status = ST_NOTFOUND;
      end
    end
    res.found = hit;
    res.index = pos[IDX_W-1:0];
    res.count = held_count[IDX_W-1:0];
    return res;
  endfunction

  // Gap before a beat; every fourth stretch of 40 beats runs without gaps.
  function automatic int unsigned draw_gap(int unsigned n);
    if ((n / 40) % 4 == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Keys lean toward held values and their neighbors so that hits and
  // duplicates are common.
  function automatic logic [KEY_W-1:0] pick_key(bit prefer_held);
    logic [KEY_W-1:0] base;
    if (prefer_held && held_count > 0 && $urandom_range(0, 99) < 85)
      return held_keys[$urandom_range(0, held_count - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4: return $urandom_range(0, 15) - 8;
      5: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h8000_0001;
          2: return 32'h7FFF_FFFE;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: begin
        if (held_count == 0) return $urandom;
        base = held_keys[$urandom_range(0, held_count - 1)];
        return base + $urandom_range(0, 2) - 1;
      end
    endcase
  endfunction

  // Operation mix for each occupancy stage.
  function automatic logic [OP_W-1:0] pick_op(load_phase_e ph);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (roll < 88) return OP_INSERT;
        if (roll < 95) return OP_FIND;
        if (roll < 98) return OP_DELETE;
      end
      PH_FULL: begin
        if (roll < 45) return OP_INSERT;
        if (roll < 75) return OP_FIND;
        if (roll < 97) return OP_DELETE;
      end
      PH_DRAIN: begin
        if (roll < 88) return OP_DELETE;
        if (roll < 95) return OP_FIND;
        if (roll < 98) return OP_INSERT;
      end
      default: begin
        if (roll < 35) return OP_INSERT;
        if (roll < 65) return OP_FIND;
        if (roll < 95) return OP_DELETE;
      end
    endcase
    return OP_SPARE;
  endfunction

  // Offers one request beat; called and returns at a falling edge.
  task automatic send_req(req_t r, bit typed, rsp_t typed_rsp);
    int unsigned gap;
    rsp_t predicted;
    gap = draw_gap(sent_beats);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = apply_table_op(r);
    if (typed) predicted = typed_rsp;
    pending_rsps = {pending_rsps, predicted};
    sent_beats++;
    @(negedge clk);
  endtask

  // Request side: reset, directed rows, random traffic, then drain.
  initial begin
    req_t r;
    rsp_t want;
    load_phase_e phase;
    int unsigned full_items;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows.
    for (int unsigned n = 0; n < DIR_ROWS; n++) begin
      r.op = DIR_TABLE[n].op;
      r.key = DIR_TABLE[n].key;
      want.found = DIR_TABLE[n].found;
      want.index = DIR_TABLE[n].index;
      want.count = DIR_TABLE[n].count;
      want.status = DIR_TABLE[n].status;
      send_req(r, DIR_TABLE[n].typed, want);
    end

    // Random traffic: fill to full, push on the full table, drain, then mix.
    phase = PH_FILL;
    full_items = 0;
    want = '0;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase == PH_FILL && held_count == TABLE_DEPTH) phase = PH_FULL;
      if (phase == PH_FULL && full_items >= FULL_ITEMS) phase = PH_DRAIN;
      if (phase == PH_DRAIN && held_count == 0) phase = PH_MIX;
      if (phase == PH_FULL) full_items++;
      r.op = pick_op(phase);
      r.key = pick_key(r.op != OP_INSERT);
      send_req(r, 1'b0, want);
    end
    req_valid <= 1'b0;

    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("sorted_table_binary_search_unit_tb: done, clean");
    end else begin
      $display("sorted_table_binary_search_unit_tb: done, errors");
    end
    $finish;
  end

  // Response side: random stalls, one long hold-off, field-by-field checks.
  initial begin
    int unsigned gap;
    rsp_t want;
    logic bad;
    @(negedge clk iff !rst);
    forever begin
      gap = (rcvd_beats == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : draw_gap(rcvd_beats + 20);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      rcvd_beats++;
      if (pending_rsps.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("response beat %0d arrived with nothing expected:", rcvd_beats,
                   " found=%0d index=%0d count=%0d status=%0d",
                   rsp.found, rsp.index, rsp.count, rsp.status);
      end else begin
        want = pending_rsps.pop_front();
        bad = (rsp.found !== want.found) || (rsp.index !== want.index) ||
              (rsp.count !== want.count) || (rsp.status !== want.status);
        if (bad) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("response beat %0d mismatch:", rcvd_beats);
            $display("  expected found=%0d index=%0d count=%0d status=%0d",
                     want.found, want.index, want.count, want.status);
            $display("  actual   found=%0d index=%0d count=%0d status=%0d",
                     rsp.found, rsp.index, rsp.count, rsp.status);
          end
        end
      end
      @(negedge clk);
    end
  end

  // Hard limit on run time.
  initial begin
    #4_000_000;
    $display("sorted_table_binary_search_unit_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/stbs_pkg.sv
sv/stbs_ram.sv
sv/sorted_table_binary_search_unit.sv
sim/sorted_table_binary_search_unit_tb.sv
